>>> sv/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants and types for the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  // window store geometry
  localparam int WINDOW_MAX    = 64;
  localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
  localparam int LEN_BITS      = SLOT_BITS + 1;

  // sample and result formats
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int SUM_BITS      = SAMPLE_BITS + SLOT_BITS;
  localparam int AVG_BITS      = 24;

  // divider: magnitude of the scaled sum, one quotient bit per step
  localparam int NUM_BITS      = SUM_BITS + FRACTION_BITS;
  localparam int STEP_BITS     = $clog2(NUM_BITS);

  // configuration port
  localparam int ADDR_BITS     = 3;
  localparam int DATA_BITS     = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RESET = LEN_BITS'(4);

  // job passed from the front end to the divider
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [LEN_BITS-1:0]        len;
  } job_t;

endpackage

>>> sv/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Boxcar moving average: the mean of the last window_length samples as
// signed fixed point with 8 fraction bits, truncated toward zero.
// ----------------------------------------------------------------------------
// Path of a sample that completes a window: front end (ring read, then sum
// update), job queue, divider load, divide steps, result register; a full
// queue or an unread result stalls it. The front end takes no new sample
// before the last has updated the sum; the radix-2 divider takes one job at a time.
// Reset: synchronous; clears sum, fill count, write slot and all queues and
// sets window_length to 4. No clearing pass; unwritten ring slots go unused.
module sliding_window_average
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic                          start_req,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [AVG_BITS-1:0]    average
);

  logic [LEN_BITS-1:0] window_length;
  logic [LEN_BITS-1:0] len_active;
  logic                cfg_write;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  job_t                q_wr_data;
  job_t                q_rd_data;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == REG_WINDOW_LENGTH);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_LENGTH) begin
      prdata = DATA_BITS'(window_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[LEN_BITS-1:0];
    end
  end

  // clamp the register to a usable window
  always_comb begin
    len_active = window_length;
    if (window_length == '0) begin
      len_active = LEN_BITS'(1);
    end else if (window_length > LEN_BITS'(WINDOW_MAX)) begin
      len_active = LEN_BITS'(WINDOW_MAX);
    end
  end

  swa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_write),
    .len       (len_active),
    .push      (push),
    .full      (full),
    .start_req (start_req),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  swa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  swa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .average (average)
  );

endmodule

>>> sv/swa_queue.sv
// ----------------------------------------------------------------------------
// swa_queue
// Two-entry queue of divide jobs between the front end and the divider.
// ----------------------------------------------------------------------------
module swa_queue
  import swa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_data,
  output logic full,
  input  logic pop,
  output job_t rd_data,
  output logic empty
);

  job_t entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job pushed into full queue");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue occupancy out of range");

endmodule

>>> sv/swa_front.sv
// ----------------------------------------------------------------------------
// swa_front
// Takes samples, keeps the ring of recent samples and the running sum, and
// hands a divide job to the queue once the window is full.
// ----------------------------------------------------------------------------
module swa_front
  import swa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic [LEN_BITS-1:0]           len,
  input  logic                          push,
  output logic                          full,
  input  logic                          start_req,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          q_full,
  output logic                          q_push,
  output job_t                          q_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;
  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic                          start;
  logic signed [SUM_BITS-1:0]    running_sum;
  logic [LEN_BITS-1:0]           fill_count;
  logic [SLOT_BITS-1:0]          write_slot;

  logic                          accept;
  logic [SLOT_BITS-1:0]          old_slot;
  logic [LEN_BITS-1:0]           fill_base;
  logic signed [SUM_BITS-1:0]    sum_base;
  logic                          drop;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic [LEN_BITS-1:0]           fill_next;
  logic                          produce;
  logic                          done;

  assign full     = (state != ST_IDLE);
  assign accept   = push && !full;
  assign old_slot = write_slot - len[SLOT_BITS-1:0];

  // new window sum: a start flag begins from an empty window
  always_comb begin
    fill_base = start ? '0 : fill_count;
    sum_base  = start ? '0 : running_sum;
    drop      = (fill_base >= len);
    sum_next  = sum_base + SUM_BITS'(smp);
    if (drop) begin
      sum_next = sum_next - SUM_BITS'(old_sample);
    end
    fill_next = drop ? fill_base : fill_base + LEN_BITS'(1);
    produce   = (fill_next >= len);
  end

  // leave the calc state unless a job is waiting on a full queue
  assign done        = (state == ST_CALC) && !(produce && q_full);
  assign q_push      = (state == ST_CALC) && produce && !q_full;
  assign q_data.sum  = sum_next;
  assign q_data.len  = len;

  // ring store: oldest sample read on accept, new sample written on completion
  always_ff @(posedge clk) begin
    if (accept) begin
      old_sample <= mem[old_slot];
      smp        <= sample;
      start      <= start_req;
    end
    if (done) begin
      mem[write_slot] <= smp;
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      fill_count  <= '0;
      write_slot  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (done) begin
            state       <= ST_IDLE;
            running_sum <= sum_next;
            fill_count  <= fill_next;
            write_slot  <= write_slot + SLOT_BITS'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (clear) begin
        running_sum <= '0;
        fill_count  <= '0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= len) else $error("fill count beyond window length");
  a_push_only_full_window: assert property (@(posedge clk) disable iff (rst)
    q_push |-> fill_next == len) else $error("job sent before window filled");
  a_calc_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CALC) else $error("accepted sample not processed");

endmodule

>>> sv/swa_back.sv
// ----------------------------------------------------------------------------
// swa_back
// Radix-2 divider: scaled window sum over window length, truncated toward
// zero, with a one-entry result register towards the consumer.
// ----------------------------------------------------------------------------
module swa_back
  import swa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  job_t                       q_data,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [AVG_BITS-1:0] average
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic                  neg;
  logic [NUM_BITS-1:0]   quo;
  logic [SLOT_BITS-1:0]  rem;
  logic [LEN_BITS-1:0]   len;
  logic [STEP_BITS-1:0]  step;
  logic                  out_valid;

  logic [SUM_BITS-1:0]   mag;
  logic [LEN_BITS-1:0]   trial;
  logic                  ge;
  logic [LEN_BITS-1:0]   diff;
  logic [AVG_BITS-1:0]   q_mag;
  logic [AVG_BITS-1:0]   result;
  logic                  out_free;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // operand magnitude and one restoring step
  always_comb begin
    mag    = q_data.sum[SUM_BITS-1] ? SUM_BITS'(0) - q_data.sum : q_data.sum;
    trial  = {rem, quo[NUM_BITS-1]};
    ge     = (trial >= len);
    diff   = trial - len;
    q_mag  = quo[AVG_BITS-1:0];
    result = neg ? AVG_BITS'(0) - q_mag : q_mag;
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg  <= q_data.sum[SUM_BITS-1];
      quo  <= {mag, {FRACTION_BITS{1'b0}}};
      rem  <= '0;
      len  <= q_data.len;
      step <= STEP_BITS'(NUM_BITS - 1);
    end else if (state == ST_DIV) begin
      rem  <= ge ? diff[SLOT_BITS-1:0] : trial[SLOT_BITS-1:0];
      quo  <= {quo[NUM_BITS-2:0], ge};
      step <= step - STEP_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      average <= $signed(result);
    end
  end

  // sequencing and result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < len) else $error("divider remainder out of range");
  a_job_starts_div: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_DIV) else $error("popped job not divided");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(average))
    else $error("waiting result overwritten");

endmodule
